// ----- rtl/core/vbrp_pkg.sv -----
// Package for the virtio block request parser.
// Holds constants, codes and the beat types shared by all rtl/core modules.
// No dependencies.
package vbrp_pkg;

    localparam int unsigned SECTOR_BYTES = 512;
    localparam int unsigned ID_BYTES     = 20;
    localparam int unsigned HEADER_BYTES = 16;

    // sector size is a power of two: multiply is a shift, remainder a mask
    localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WR_PROTECT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_LENGTH  = 1'd1;

    localparam logic [31:0] REQ_TYPE_IN    = 32'd0;
    localparam logic [31:0] REQ_TYPE_OUT   = 32'd1;
    localparam logic [31:0] REQ_TYPE_FLUSH = 32'd4;
    localparam logic [31:0] REQ_TYPE_GETID = 32'd8;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_READ       = 3'd1,
        ACT_WRITE      = 3'd2,
        ACT_FLUSH      = 3'd3,
        ACT_COPY_ID    = 3'd4,
        ACT_FIN_STATUS = 3'd5,
        ACT_FIN_NOSTAT = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_IOERR  = 2'd1,
        ST_UNSUPP = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        KIND_READ  = 5'b00001,
        KIND_WRITE = 5'b00010,
        KIND_FLUSH = 5'b00100,
        KIND_ID    = 5'b01000,
        KIND_ERROR = 5'b10000
    } kind_t;

    typedef struct packed {
        logic [31:0] len;
        logic        writable;
        logic        last;
        logic [31:0] req_type;
        logic [63:0] req_sector;
    } desc_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] byte_offset;
        logic [31:0] byte_count;
        status_t     status_code;
        logic [31:0] used_bytes;
        logic        chain_done;
    } result_t;

endpackage

// ----- rtl/core/vbrp_in_stage.sv -----
// Input register stage of the request parser: holds one descriptor beat.
// Depends on vbrp_pkg.
module vbrp_in_stage import vbrp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  desc_t in_desc,
    output logic  held_valid,
    input  logic  held_take,
    output desc_t held_desc
);

    logic  valid_reg;
    logic  valid_next;
    desc_t desc_reg;

    assign in_ready   = !valid_reg || held_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !held_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            desc_reg <= in_desc;
        end
    end

    assign held_valid = valid_reg;
    assign held_desc  = desc_reg;

endmodule

// ----- rtl/core/vbrp_core.sv -----
// Request state and per-descriptor decode of the request parser.
// Holds the config registers and chain state; depends on vbrp_pkg.
module vbrp_core import vbrp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   load,
    input  desc_t                  desc,
    output result_t                res
);

    localparam logic [8:0]  ID_BYTES_W  = 9'(ID_BYTES);
    localparam logic [31:0] HEADER_LEN  = 32'(HEADER_BYTES);
    localparam logic [31:0] ID_LEN      = 32'(ID_BYTES);

    logic        wr_protect_reg;
    logic [7:0]  id_length_reg;

    logic        in_body_reg,  in_body_next;
    kind_t       kind_reg,     kind_next;
    status_t     status_reg,   status_next;
    logic [63:0] offset_reg,   offset_next;
    logic [31:0] used_reg,     used_next;

    logic        status_byte;
    logic        want_wr;
    logic [8:0]  id_plus1;
    logic [8:0]  id_count;
    logic        data_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_protect_reg <= 1'b0;
            id_length_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WR_PROTECT: wr_protect_reg <= cfg_wdata[0];
                CFG_ID_LENGTH:  id_length_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign status_byte = (desc.len == 32'd1) && desc.writable && desc.last;
    assign want_wr     = (kind_reg == KIND_READ) || (kind_reg == KIND_ID);
    assign data_kind   = (kind_reg == KIND_READ) || (kind_reg == KIND_WRITE);
    assign id_plus1    = {1'b0, id_length_reg} + 9'd1;
    assign id_count    = (id_plus1 > ID_BYTES_W) ? ID_BYTES_W : id_plus1;

    always_comb begin
        in_body_next = in_body_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        offset_next  = offset_reg;
        used_next    = used_reg;

        res.action      = ACT_NONE;
        res.byte_offset = '0;
        res.byte_count  = '0;
        res.chain_done  = 1'b0;

        if (!in_body_reg) begin
            status_next = ST_OK;
            used_next   = '0;
            offset_next = '0;
            kind_next   = KIND_ERROR;
            if (status_byte) begin
                status_next    = ST_IOERR;
                res.action     = ACT_FIN_STATUS;
                res.chain_done = 1'b1;
            end else if (desc.writable || desc.last || desc.len != HEADER_LEN) begin
                status_next = ST_IOERR;
                if (desc.last) begin
                    res.action     = ACT_FIN_NOSTAT;
                    res.chain_done = 1'b1;
                end else begin
                    in_body_next = 1'b1;
                end
            end else begin
                in_body_next = 1'b1;
                offset_next  = desc.req_sector << SECTOR_SHIFT;
                case (desc.req_type)
                    REQ_TYPE_IN: kind_next = KIND_READ;
                    REQ_TYPE_OUT: begin
                        if (wr_protect_reg) begin
                            status_next = ST_IOERR;
                        end else begin
                            kind_next = KIND_WRITE;
                        end
                    end
                    REQ_TYPE_FLUSH: begin
                        if (desc.req_sector != '0) begin
                            status_next = ST_IOERR;
                        end else begin
                            kind_next  = KIND_FLUSH;
                            res.action = ACT_FLUSH;
                        end
                    end
                    REQ_TYPE_GETID: kind_next = KIND_ID;
                    default: status_next = ST_UNSUPP;
                endcase
            end
        end else if (status_byte) begin
            in_body_next   = 1'b0;
            res.action     = ACT_FIN_STATUS;
            res.chain_done = 1'b1;
        end else begin
            if (desc.writable != want_wr) begin
                status_next = ST_IOERR;
            end
            if (desc.last) begin
                in_body_next   = 1'b0;
                res.action     = ACT_FIN_NOSTAT;
                res.chain_done = 1'b1;
            end else if (status_next != ST_OK) begin
                res.action = ACT_NONE;
            end else if (data_kind) begin
                if (desc.len[SECTOR_SHIFT-1:0] != '0) begin
                    status_next = ST_IOERR;
                end else begin
                    offset_next     = offset_reg + {32'd0, desc.len};
                    res.byte_offset = offset_reg;
                    res.byte_count  = desc.len;
                    if (kind_reg == KIND_READ) begin
                        used_next  = used_reg + desc.len;
                        res.action = ACT_READ;
                    end else begin
                        res.action = ACT_WRITE;
                    end
                end
            end else if (kind_reg == KIND_ID) begin
                if (desc.len != ID_LEN) begin
                    status_next = ST_IOERR;
                end else begin
                    used_next      = used_reg + {23'd0, id_count};
                    res.byte_count = {23'd0, id_count};
                    res.action     = ACT_COPY_ID;
                end
            end
        end

        res.status_code = status_next;
        res.used_bytes  = used_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg <= 1'b0;
            kind_reg    <= KIND_READ;
            status_reg  <= ST_OK;
            offset_reg  <= '0;
            used_reg    <= '0;
        end else if (load) begin
            in_body_reg <= in_body_next;
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            offset_reg  <= offset_next;
            used_reg    <= used_next;
        end
    end

    a_done_ends_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        load && res.chain_done |=> !in_body_reg)
        else $error("chain still open after finishing beat");

    a_cmd_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (res.action == ACT_READ || res.action == ACT_WRITE
                 || res.action == ACT_COPY_ID) |-> res.status_code == ST_OK)
        else $error("command issued with bad status");

    a_header_clears_used: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !in_body_reg |=> used_reg == '0)
        else $error("used count not cleared on header");

    a_write_keeps_used: assert property (@(posedge aclk) disable iff (!aresetn)
        load && in_body_reg && kind_reg == KIND_WRITE |=> $stable(used_reg))
        else $error("write request changed used count");

endmodule

// ----- rtl/core/vbrp_out_stage.sv -----
// Result register stage of the request parser: holds one result beat.
// Depends on vbrp_pkg.
module vbrp_out_stage import vbrp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    src_valid,
    output logic    load,
    input  result_t src_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign load       = src_valid && (!valid_reg || out_ready);
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= src_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/core/virtio_block_request_parser.sv -----
// Virtio block request parser, top level.
// Channels: s_* takes one descriptor beat of a request chain (header first,
//   then data descriptors, then the status byte); m_* gives one result beat
//   per descriptor: the command to run, status and used byte count.
// Config: cfg_wr_en/cfg_index/cfg_wdata write the write-protect flag (0) and
//   id_length (1); write only while no descriptor is in flight.
// Path: an accepted descriptor is held in the input register, decoded
//   combinationally, and its result is registered once the result register is free.
// Throughput: one descriptor per cycle while m_ready does not hold the result
//   register, set by the input register feeding the combinational decode and the result register.
// Stall: while m_ready is low the held result stays put and one more
//   descriptor waits in the input register; s_ready then drops.
// Reset (aresetn low, synchronous): both stages empty, chain state back to
//   awaiting a header, config registers cleared. No clearing pass.
// Depends on vbrp_pkg, vbrp_in_stage, vbrp_core, vbrp_out_stage.
module virtio_block_request_parser import vbrp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_desc_len,
    input  logic                   s_desc_writable,
    input  logic                   s_desc_last,
    input  logic [31:0]            s_req_type,
    input  logic [63:0]            s_req_sector,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_action,
    output logic [63:0]            m_byte_offset,
    output logic [31:0]            m_byte_count,
    output logic [1:0]             m_status_code,
    output logic [31:0]            m_used_bytes,
    output logic                   m_chain_done
);

    desc_t   in_desc;
    desc_t   held_desc;
    logic    held_valid;
    logic    load;
    result_t core_res;
    result_t out_res;

    assign in_desc.len        = s_desc_len;
    assign in_desc.writable   = s_desc_writable;
    assign in_desc.last       = s_desc_last;
    assign in_desc.req_type   = s_req_type;
    assign in_desc.req_sector = s_req_sector;

    vbrp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_desc    (in_desc),
        .held_valid (held_valid),
        .held_take  (load),
        .held_desc  (held_desc)
    );

    vbrp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .load      (load),
        .desc      (held_desc),
        .res       (core_res)
    );

    vbrp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .src_valid (held_valid),
        .load      (load),
        .src_res   (core_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_action      = out_res.action;
    assign m_byte_offset = out_res.byte_offset;
    assign m_byte_count  = out_res.byte_count;
    assign m_status_code = out_res.status_code;
    assign m_used_bytes  = out_res.used_bytes;
    assign m_chain_done  = out_res.chain_done;

endmodule

// ----- verif/tb_top.sv -----
// Testbench for virtio_block_request_parser: directed chains, then random chains.
// A local predictor of the parser state checks every result beat in order.
// Depends on vbrp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_top;
    import vbrp_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [31:0]            s_desc_len;
    logic                   s_desc_writable;
    logic                   s_desc_last;
    logic [31:0]            s_req_type;
    logic [63:0]            s_req_sector;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_action;
    logic [63:0]            m_byte_offset;
    logic [31:0]            m_byte_count;
    logic [1:0]             m_status_code;
    logic [31:0]            m_used_bytes;
    logic                   m_chain_done;

    virtio_block_request_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_desc_len      (s_desc_len),
        .s_desc_writable (s_desc_writable),
        .s_desc_last     (s_desc_last),
        .s_req_type      (s_req_type),
        .s_req_sector    (s_req_sector),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_byte_offset   (m_byte_offset),
        .m_byte_count    (m_byte_count),
        .m_status_code   (m_status_code),
        .m_used_bytes    (m_used_bytes),
        .m_chain_done    (m_chain_done)
    );

    // parser state mirror
    bit          body_open   = 1'b0;
    kind_t       req_kind    = KIND_READ;
    status_t     req_status  = ST_OK;
    logic [63:0] run_offset  = '0;
    logic [31:0] guest_bytes = '0;
    bit          ro_mode     = 1'b0;
    logic [7:0]  id_len_cfg  = '0;

    result_t     pending_results[$];
    int unsigned fail_cnt   = 0;
    int unsigned burst_left = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic result_t parse_descriptor(input logic [31:0] len, input logic wr,
                                                 input logic last, input logic [31:0] rtype,
                                                 input logic [63:0] sector);
        result_t     r;
        logic        stat_byte;
        logic        want_wr;
        logic [31:0] n;
        stat_byte     = (len == 32'd1) && wr && last;
        r.action      = ACT_NONE;
        r.byte_offset = '0;
        r.byte_count  = '0;
        r.chain_done  = 1'b0;
        if (!body_open) begin
            req_status  = ST_OK;
            guest_bytes = '0;
            run_offset  = '0;
            req_kind    = KIND_ERROR;
            if (stat_byte) begin
                req_status   = ST_IOERR;
                r.action     = ACT_FIN_STATUS;
                r.chain_done = 1'b1;
            end else if (wr || last || len != HEADER_BYTES) begin
                req_status = ST_IOERR;
                if (last) begin
                    r.action     = ACT_FIN_NOSTAT;
                    r.chain_done = 1'b1;
                end else begin
                    body_open = 1'b1;
                end
            end else begin
                body_open  = 1'b1;
                run_offset = sector * 64'(SECTOR_BYTES);
                case (rtype)
                    REQ_TYPE_IN: begin
                        req_kind = KIND_READ;
                    end
                    REQ_TYPE_OUT: begin
                        if (ro_mode) req_status = ST_IOERR;
                        else req_kind = KIND_WRITE;
                    end
                    REQ_TYPE_FLUSH: begin
                        if (sector != '0) begin
                            req_status = ST_IOERR;
                        end else begin
                            req_kind = KIND_FLUSH;
                            r.action = ACT_FLUSH;
                        end
                    end
                    REQ_TYPE_GETID: begin
                        req_kind = KIND_ID;
                    end
                    default: begin
                        req_status = ST_UNSUPP;
                    end
                endcase
            end
        end else if (stat_byte) begin
            body_open    = 1'b0;
            r.action     = ACT_FIN_STATUS;
            r.chain_done = 1'b1;
        end else begin
            want_wr = (req_kind == KIND_READ) || (req_kind == KIND_ID);
            if (wr != want_wr) req_status = ST_IOERR;
            if (last) begin
                body_open    = 1'b0;
                r.action     = ACT_FIN_NOSTAT;
                r.chain_done = 1'b1;
            end else if (req_status == ST_OK) begin
                if (req_kind == KIND_READ || req_kind == KIND_WRITE) begin
                    if ((len % SECTOR_BYTES) != 0) begin
                        req_status = ST_IOERR;
                    end else begin
                        r.byte_offset = run_offset;
                        r.byte_count  = len;
                        run_offset    = run_offset + 64'(len);
                        if (req_kind == KIND_READ) begin
                            guest_bytes = guest_bytes + len;
                            r.action    = ACT_READ;
                        end else begin
                            r.action    = ACT_WRITE;
                        end
                    end
                end else if (req_kind == KIND_ID) begin
                    if (len != ID_BYTES) begin
                        req_status = ST_IOERR;
                    end else begin
                        n = {24'd0, id_len_cfg} + 32'd1;
                        if (n > len) n = len;
                        guest_bytes  = guest_bytes + n;
                        r.action     = ACT_COPY_ID;
                        r.byte_count = n;
                    end
                end
            end
        end
        r.status_code = req_status;
        r.used_bytes  = guest_bytes;
        return r;
    endfunction

    task automatic send_desc(input logic [31:0] len, input logic wr, input logic last,
                             input logic [31:0] rtype, input logic [63:0] sector);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_desc_len      <= len;
        s_desc_writable <= wr;
        s_desc_last     <= last;
        s_req_type      <= rtype;
        s_req_sector    <= sector;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(parse_descriptor(len, wr, last, rtype, sector));
    endtask

    task automatic send_header(input logic [31:0] rtype, input logic [63:0] sector);
        send_desc(HEADER_BYTES, 1'b0, 1'b0, rtype, sector);
    endtask

    task automatic send_data(input logic [31:0] len, input logic wr);
        send_desc(len, wr, 1'b0, $urandom, {$urandom, $urandom});
    endtask

    task automatic send_status();
        send_desc(32'd1, 1'b1, 1'b1, $urandom, {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic set_config(input bit ro, input logic [7:0] idl);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WR_PROTECT;
        cfg_wdata <= {7'($urandom), ro};
        @(posedge aclk);
        cfg_index <= CFG_ID_LENGTH;
        cfg_wdata <= idl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ro_mode    = ro;
        id_len_cfg = idl;
    endtask

    task automatic test_header_faults();
        send_status();
        send_desc(HEADER_BYTES, 1'b1, 1'b1, REQ_TYPE_IN, '0);
        send_desc(32'hFFFF_FFFF, 1'b0, 1'b0, REQ_TYPE_IN, '0);
        send_status();
    endtask

    task automatic test_read_write();
        // offset wraps past 2^64
        send_header(REQ_TYPE_IN, '1);
        send_data(32'hFFFF_FE00, 1'b1);
        send_data(32'd0, 1'b1);
        send_status();
        send_header(REQ_TYPE_OUT, 64'd1);
        send_data(SECTOR_BYTES, 1'b0);
        send_data(32'd100, 1'b0);
        send_status();
    endtask

    task automatic test_flush();
        send_header(REQ_TYPE_FLUSH, '0);
        send_data(SECTOR_BYTES, 1'b0);
        send_status();
        send_header(REQ_TYPE_FLUSH, 64'd5);
        send_status();
    endtask

    task automatic test_get_id_read_only();
        send_header(REQ_TYPE_GETID, '0);
        send_data(ID_BYTES, 1'b1);
        send_status();
        wait_idle();
        set_config(1'b1, 8'd255);
        send_header(REQ_TYPE_GETID, '0);
        send_data(ID_BYTES, 1'b1);
        send_status();
        send_header(REQ_TYPE_OUT, '0);
        send_status();
    endtask

    task automatic test_unsupported();
        send_header(32'hFFFF_FFFF, '1);
        send_desc(32'd1, 1'b0, 1'b1, $urandom, {$urandom, $urandom});
        wait_idle();
        set_config(1'b0, 8'd0);
    endtask

    task automatic test_random_chains();
        int unsigned sent;
        int unsigned next_cfg;
        int unsigned n_data;
        logic [31:0] rtype;
        logic [63:0] sector;
        logic [31:0] len;
        logic        want_wr;
        logic        wr;
        logic [7:0]  idl;
        sent     = 0;
        next_cfg = 200;
        while (sent < 800) begin
            if (sent >= next_cfg) begin
                wait_idle();
                case ($urandom_range(0, 4))
                    0: idl = 8'd0;
                    1: idl = 8'd255;
                    2: idl = 8'd19;
                    3: idl = 8'd20;
                    default: idl = 8'($urandom_range(0, 255));
                endcase
                set_config(1'($urandom_range(0, 1)), idl);
                next_cfg += 200;
            end
            if ($urandom_range(0, 99) < 12) begin
                // noise beat
                case ($urandom_range(0, 3))
                    0: len = 32'd1;
                    1: len = HEADER_BYTES;
                    2: len = 32'($urandom_range(0, 2) * SECTOR_BYTES);
                    default: len = $urandom;
                endcase
                send_desc(len, 1'($urandom), 1'($urandom), $urandom, {$urandom, $urandom});
                sent++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: rtype = REQ_TYPE_IN;
                    3, 4, 5: rtype = REQ_TYPE_OUT;
                    6:       rtype = REQ_TYPE_FLUSH;
                    7, 8:    rtype = REQ_TYPE_GETID;
                    default: rtype = $urandom;
                endcase
                sector = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(0, 1000));
                if (rtype == REQ_TYPE_FLUSH && $urandom_range(0, 3) != 0) sector = '0;
                send_header(rtype, sector);
                want_wr = (rtype == REQ_TYPE_IN) || (rtype == REQ_TYPE_GETID);
                n_data  = $urandom_range(0, 4);
                repeat (n_data) begin
                    wr = ($urandom_range(0, 15) == 0) ? ~want_wr : want_wr;
                    if (rtype == REQ_TYPE_GETID) begin
                        len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 40))
                                                          : ID_BYTES;
                    end else begin
                        case ($urandom_range(0, 9))
                            0: len = $urandom;
                            1: len = $urandom & ~32'(SECTOR_BYTES - 1);
                            default: len = 32'($urandom_range(0, 16) * SECTOR_BYTES);
                        endcase
                    end
                    send_data(len, wr);
                    sent++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_status();
                end else begin
                    send_desc(32'($urandom_range(0, 3)), 1'($urandom), 1'b1, $urandom,
                              {$urandom, $urandom});
                end
                sent += 2;
            end
        end
    endtask

    // receiver stall pattern, rotating through four ready modes
    initial begin : receiver
        int unsigned cyc;
        cyc = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            case ((cyc >> 8) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ((cyc % 5) != 0);
                default: m_ready <= ((cyc % 32) < 20);
            endcase
            cyc++;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected result beat: action %0d", m_action);
            end else begin
                want_r = pending_results.pop_front();
                if (m_action !== want_r.action || m_byte_offset !== want_r.byte_offset ||
                    m_byte_count !== want_r.byte_count ||
                    m_status_code !== want_r.status_code ||
                    m_used_bytes !== want_r.used_bytes || m_chain_done !== want_r.chain_done)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("mismatch exp/act: action %0d/%0d off %h/%h cnt %h/%h",
                                 want_r.action, m_action, want_r.byte_offset, m_byte_offset,
                                 want_r.byte_count, m_byte_count);
                        $display("    status %0d/%0d used %h/%h done %0d/%0d",
                                 want_r.status_code, m_status_code, want_r.used_bytes,
                                 m_used_bytes, want_r.chain_done, m_chain_done);
                    end
                end
            end
        end
    end

    initial begin
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_WR_PROTECT;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_desc_len      <= '0;
        s_desc_writable <= 1'b0;
        s_desc_last     <= 1'b0;
        s_req_type      <= '0;
        s_req_sector    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_header_faults();
        test_read_write();
        test_flush();
        test_get_id_read_only();
        test_unsupported();
        test_random_chains();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
